// File: hdl/cmdtc_pkg.sv
// ============================================================================
// cmdtc_pkg
// Types, character codes and keyword tables for the command tokenizer and
// classifier.
// ============================================================================
package cmdtc_pkg;

    localparam int KW_COUNT   = 7;
    localparam int KW_SLOTS   = 8;   // one slot per position code, padded with zero
    localparam int POS_W      = 3;

    localparam logic [POS_W-1:0] POS_MAX = 3'd7;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_SEMI   = 8'h3b;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // create, insert, select, update, delete, drop, show
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{"c", "r", "e", "a", "t", "e", 8'h00, 8'h00},
        '{"i", "n", "s", "e", "r", "t", 8'h00, 8'h00},
        '{"s", "e", "l", "e", "c", "t", 8'h00, 8'h00},
        '{"u", "p", "d", "a", "t", "e", 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00},
        '{"d", "r", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "h", "o", "w", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd4
    };

    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_BARE   = 2'd1,
        PHASE_QUOTED = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLASS_UNKNOWN = 2'd0,
        CLASS_REDIS   = 2'd1,
        CLASS_SQL     = 2'd2
    } class_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_command;
    } cmd_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       token_end;
        logic       in_first_token;
        logic       command_done;
        logic [1:0] command_class;
    } cmd_out_t;

    typedef struct packed {
        phase_t              phase;
        logic                quote_kind;     // 1: double quote
        logic                any_token_seen;
        logic                first_token_closed;
        logic [POS_W-1:0]    first_token_position;
        logic [KW_COUNT-1:0] keyword_match_bits;
        logic                keyword_hit;
    } tok_state_t;

    localparam tok_state_t STATE_RESET = '{
        phase:                PHASE_IDLE,
        quote_kind:           1'b0,
        any_token_seen:       1'b0,
        first_token_closed:   1'b0,
        first_token_position: '0,
        keyword_match_bits:   '1,
        keyword_hit:          1'b0
    };

endpackage

// File: hdl/cmdtc_step.sv
// ============================================================================
// cmdtc_step
// Per-byte tokenizer step: next state and the result for one command byte.
// ============================================================================
module cmdtc_step (
    input  cmdtc_pkg::tok_state_t st,
    input  cmdtc_pkg::cmd_in_t    din,
    output cmdtc_pkg::tok_state_t st_next,
    output cmdtc_pkg::cmd_out_t   dout
);

    logic       is_sep;
    logic       is_quote;
    logic       emit;
    logic       tok_end;
    logic       first;
    logic       hit;
    logic [7:0] c;
    logic [7:0] close_quote;
    logic [1:0] cls;

    assign is_sep = (din.byte_in == cmdtc_pkg::CHAR_SPACE)
                 || (din.byte_in == cmdtc_pkg::CHAR_SEMI)
                 || ((din.byte_in >= cmdtc_pkg::CHAR_TAB) && (din.byte_in <= cmdtc_pkg::CHAR_CR));
    assign is_quote = (din.byte_in == cmdtc_pkg::CHAR_SQUOTE)
                   || (din.byte_in == cmdtc_pkg::CHAR_DQUOTE);
    assign close_quote = st.quote_kind ? cmdtc_pkg::CHAR_DQUOTE : cmdtc_pkg::CHAR_SQUOTE;

    always_comb begin
        st_next = st;
        emit    = 1'b0;
        tok_end = 1'b0;
        hit     = 1'b0;
        c       = din.byte_in;
        cls     = cmdtc_pkg::CLASS_UNKNOWN;

        case (st.phase)
            cmdtc_pkg::PHASE_BARE: begin
                if (is_sep) begin
                    tok_end = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            cmdtc_pkg::PHASE_QUOTED: begin
                if (din.byte_in == close_quote) begin
                    tok_end = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
                st_next.phase = cmdtc_pkg::PHASE_IDLE;
                if (is_quote) begin
                    st_next.phase          = cmdtc_pkg::PHASE_QUOTED;
                    st_next.quote_kind     = (din.byte_in == cmdtc_pkg::CHAR_DQUOTE);
                    st_next.any_token_seen = 1'b1;
                end else if (!is_sep) begin
                    st_next.phase          = cmdtc_pkg::PHASE_BARE;
                    st_next.any_token_seen = 1'b1;
                    emit                   = 1'b1;
                end
            end
        endcase

        first = st_next.any_token_seen && !st.first_token_closed;

        // first token: lowercase and narrow the keyword candidates
        if (emit && first) begin
            if ((c >= cmdtc_pkg::CHAR_UPPER_A) && (c <= cmdtc_pkg::CHAR_UPPER_Z)) begin
                c = c + cmdtc_pkg::CASE_OFFSET;
            end
            for (int k = 0; k < cmdtc_pkg::KW_COUNT; k++) begin
                if (!((st.first_token_position < cmdtc_pkg::KW_LEN[k])
                      && (cmdtc_pkg::KW_TEXT[k][st.first_token_position] == c))) begin
                    st_next.keyword_match_bits[k] = 1'b0;
                end
            end
            if (st.first_token_position != cmdtc_pkg::POS_MAX) begin
                st_next.first_token_position = st.first_token_position + 1'b1;
            end
        end

        if (din.end_of_command && (st_next.phase != cmdtc_pkg::PHASE_IDLE)) begin
            tok_end = 1'b1;
        end

        if (tok_end) begin
            if (first) begin
                for (int k = 0; k < cmdtc_pkg::KW_COUNT; k++) begin
                    if (st_next.keyword_match_bits[k]
                        && (cmdtc_pkg::KW_LEN[k] == st_next.first_token_position)) begin
                        hit = 1'b1;
                    end
                end
                st_next.keyword_hit        = hit;
                st_next.first_token_closed = 1'b1;
            end
            st_next.phase = cmdtc_pkg::PHASE_IDLE;
        end

        if (din.end_of_command) begin
            if (!st_next.any_token_seen) begin
                cls = cmdtc_pkg::CLASS_UNKNOWN;
            end else if (st_next.keyword_hit) begin
                cls = cmdtc_pkg::CLASS_SQL;
            end else begin
                cls = cmdtc_pkg::CLASS_REDIS;
            end
        end

        dout.char_out       = emit ? c : 8'h00;
        dout.char_valid     = emit;
        dout.token_end      = tok_end;
        dout.in_first_token = first && (emit || tok_end);
        dout.command_done   = din.end_of_command;
        dout.command_class  = cls;

        // everything clears at the end of a command
        if (din.end_of_command) begin
            st_next = cmdtc_pkg::STATE_RESET;
        end
    end

endmodule

// File: hdl/command_tokenizer_classifier.sv
// ============================================================================
// command_tokenizer_classifier
// Splits a command byte stream into tokens and classifies each command.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one command byte per transaction plus an
//   end-of-command flag. m_valid/m_ready/m_data return exactly one result per
//   byte, in order: token character (lowercased in the first token), token
//   end mark, first-token flag and, on the last byte, the command class.
//   The input register loads at the accepting edge and the result register
//   loads from it through the tokenizer step when the result register is
//   free or draining, so m_data comes straight from a register.
//   Throughput is one byte per cycle while the receiver does not stall, set
//   by the combinational tokenizer step between the two registers.
//   Tokenizer state clears after every final byte, so commands are
//   independent.
//   Reset (aresetn low at a clock edge) empties both registers and returns
//   the tokenizer to the between-tokens state.
//   When the receiver stalls the result register holds, the input register
//   fills, and s_ready drops only once both are occupied; no data is lost.
// ============================================================================
module command_tokenizer_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cmdtc_pkg::cmd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cmdtc_pkg::cmd_out_t m_data
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    cmdtc_pkg::cmd_in_t    in_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    cmdtc_pkg::cmd_out_t   out_data_reg;
    cmdtc_pkg::tok_state_t state_reg;
    cmdtc_pkg::tok_state_t state_next;
    cmdtc_pkg::cmd_out_t   step_out;
    logic                  advance;
    logic                  s_take;

    cmdtc_step u_step (
        .st      (state_reg),
        .din     (in_data_reg),
        .st_next (state_next),
        .dout    (step_out)
    );

    // result register free or draining this cycle
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (s_take) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= cmdtc_pkg::STATE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= step_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
